/* rtl/core/iou_box_tracker_assert.svh */
// Assertion macros used by the checker file of the tracker.
`ifndef IOU_BOX_TRACKER_ASSERT_SVH
`define IOU_BOX_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define IOU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tracker check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define IOU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tracker check failed");

`endif

/* rtl/core/iou_bt_pkg.sv */
package iou_bt_pkg;

	localparam int MAX_TRACKS  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W = $clog2(MAX_TRACKS);
	localparam int CNT_W = $clog2(MAX_TRACKS + 1);
	localparam int RES_W = $clog2(MAX_RESULTS);

	localparam logic [4:0] HITS_CAP     = 5'd30;
	localparam logic [7:0] STREAK_MAX   = 8'd255;
	localparam logic [2:0] MISSED_LIMIT = 3'd4;

	// x / 5 == (x * RECIP5) >> RECIP_SHIFT, exact for x below 2**22
	localparam logic [19:0] RECIP5      = 20'd838861;
	localparam int          RECIP_SHIFT = 22;

	// configuration register indexes
	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_STABLE    = 1'b1;

	// command codes
	localparam logic CMD_DETECT = 1'b0;
	localparam logic CMD_CLOSE  = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] box_x;
		logic [15:0] box_y;
		logic [15:0] box_w;
		logic [15:0] box_h;
		logic [3:0]  obj_class;
		logic [15:0] confidence;
	} det_t;

	typedef struct packed {
		logic        valid_res;
		logic [15:0] out_x;
		logic [15:0] out_y;
		logic [15:0] out_w;
		logic [15:0] out_h;
		logic [3:0]  out_class;
		logic [15:0] out_confidence;
		logic        last;
		logic        overflow;
	} res_t;

endpackage

/* rtl/core/iou_box_tracker.sv */
// Channel    Direction  Handshake              Payload
// det        in         det_valid / det_ready  det_t: one detection or a frame close
// res        out        res_valid / res_ready  res_t: one reported track
// cfg        in         cfg_we                 cfg_idx selects register, cfg_data
//
// Detection: area, then a scan of the tracks; a track of another class or already
// matched is skipped, a same-class unmatched one gets its IoU (no divide if the
// union is empty), and a match updates the box and confidence. Frame close ages
// and compacts the table, then scans it for reporting, waiting on each result.
// Reset empties the table at once; det_ready is high only while idle, so a stalled
// result holds it low.
module iou_box_tracker
	import iou_bt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        det_valid,
	output logic        det_ready,
	input  det_t        det,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_DAREA, S_SCAN, S_INTER, S_TAREA, S_DIV0, S_DIV, S_CMP,
		S_DECIDE, S_UPD, S_AGE, S_EMIT, S_WAIT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] thr_q;
	logic [7:0]  stable_q;

	// track table
	logic [3:0][15:0] tbox_q   [MAX_TRACKS];
	logic [3:0]       tcls_q   [MAX_TRACKS];
	logic [15:0]      tconf_q  [MAX_TRACKS];
	logic [4:0]       thits_q  [MAX_TRACKS];
	logic [7:0]       tstreak_q[MAX_TRACKS];
	logic [2:0]       tmiss_q  [MAX_TRACKS];
	logic [MAX_TRACKS-1:0] matched_q, fresh_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;

	// current detection
	logic [3:0][15:0] dbox_q;
	logic [3:0]       dcls_q;
	logic [15:0]      dconf_q;

	// sequencer registers
	logic [CNT_W-1:0] idx_q, wp_q;
	logic [IDX_W-1:0] best_q;
	logic             best_vld_q;
	logic [16:0]      best_iou_q;
	logic [31:0]      area_d_q;
	logic [16:0]      iw_q, ih_q;
	logic [33:0]      inter_q, uni_q, rem_q;
	logic [16:0]      quo_q;
	logic [3:0]       div_cnt_q;
	logic [2:0]       upd_k_q;
	logic [RES_W-1:0] n_q;
	logic             res_valid_q;
	res_t             res_q;

	logic [IDX_W-1:0] cur;
	logic [3:0][15:0] tb;
	assign cur = idx_q[IDX_W-1:0];
	assign tb  = tbox_q[cur];

	// overlap extents of the current track and the detection
	logic [16:0] ax2, bx2, ay2, by2, lx, ly, hx, hy, iw, ih;
	always_comb begin
		ax2 = {1'b0, tb[0]} + {1'b0, tb[2]};
		bx2 = {1'b0, dbox_q[0]} + {1'b0, dbox_q[2]};
		ay2 = {1'b0, tb[1]} + {1'b0, tb[3]};
		by2 = {1'b0, dbox_q[1]} + {1'b0, dbox_q[3]};
		lx  = (tb[0] > dbox_q[0]) ? {1'b0, tb[0]} : {1'b0, dbox_q[0]};
		ly  = (tb[1] > dbox_q[1]) ? {1'b0, tb[1]} : {1'b0, dbox_q[1]};
		hx  = (ax2 < bx2) ? ax2 : bx2;
		hy  = (ay2 < by2) ? ay2 : by2;
		iw  = (hx > lx) ? hx - lx : '0;
		ih  = (hy > ly) ? hy - ly : '0;
	end

	// blended sums, pre-shifted so that one divide by five remains
	logic [20:0] bsum;
	logic [19:0] csum;
	logic [18:0] usum;
	logic [15:0] uold, unew;
	always_comb begin
		uold = tbox_q[best_q][upd_k_q[1:0]];
		unew = dbox_q[upd_k_q[1:0]];
		bsum = 21'(uold) * 21'd11 + 21'(unew) * 21'd9 + 21'd10;
		csum = 20'(tconf_q[best_q]) * 20'd7 + 20'(dconf_q) * 20'd3 + 20'd5;
		usum = (upd_k_q == 3'd4) ? csum[19:1] : bsum[20:2];
	end

	// shared multiplier
	logic [19:0] mul_a, mul_b;
	logic [39:0] mul_p;
	always_comb begin
		case (state_q)
			S_DAREA: begin mul_a = {4'b0, dbox_q[2]}; mul_b = {4'b0, dbox_q[3]}; end
			S_INTER: begin mul_a = {3'b0, iw_q}; mul_b = {3'b0, ih_q}; end
			S_TAREA: begin mul_a = {4'b0, tb[2]}; mul_b = {4'b0, tb[3]}; end
			S_UPD:   begin mul_a = {1'b0, usum}; mul_b = RECIP5; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		mul_p = mul_a * mul_b;
	end

	logic [15:0] quot, cnew;
	logic [33:0] uni_d;
	logic [34:0] rem2;
	assign quot  = mul_p[RECIP_SHIFT +: 16];
	assign cnew  = (quot > dconf_q) ? quot : dconf_q;
	assign uni_d = {2'b0, area_d_q} + {2'b0, mul_p[31:0]} - inter_q;
	assign rem2  = {rem_q, 1'b0};

	// ageing of the current track on frame close
	logic [2:0] miss_new;
	logic       keep;
	assign miss_new = tmiss_q[cur] + {2'b0, ~matched_q[cur] & ~fresh_q[cur]};
	assign keep     = (miss_new <= MISSED_LIMIT);

	// visible tracks and whether one lies beyond the scan index
	logic [MAX_TRACKS-1:0] vis;
	logic                  above_any;
	always_comb begin
		above_any = 1'b0;
		for (int j = 0; j < MAX_TRACKS; j++) begin
			vis[j] = (CNT_W'(j) < count_q) && (tstreak_q[j] >= stable_q)
				&& (tmiss_q[j] == 3'd0);
			if (vis[j] && (CNT_W'(j) > idx_q))
				above_any = 1'b1;
		end
	end

	logic is_match, at_end;
	assign is_match = best_vld_q && (best_iou_q >= {1'b0, thr_q});
	assign at_end   = (idx_q >= count_q);

	// next result: the current track, or a blank closing report when none is visible
	res_t res_d;
	always_comb begin
		res_d          = '0;
		res_d.overflow = ovf_q;
		res_d.last     = 1'b1;
		if (!at_end) begin
			res_d.valid_res      = 1'b1;
			res_d.out_x          = tb[0];
			res_d.out_y          = tb[1];
			res_d.out_w          = tb[2];
			res_d.out_h          = tb[3];
			res_d.out_class      = tcls_q[cur];
			res_d.out_confidence = tconf_q[cur];
			res_d.last           = (n_q == RES_W'(MAX_RESULTS - 1)) || !above_any;
		end
	end

	// track table and detection payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && det_valid) begin
			dbox_q  <= {det.box_h, det.box_w, det.box_y, det.box_x};
			dcls_q  <= det.obj_class;
			dconf_q <= det.confidence;
		end
		case (state_q)
			S_DECIDE: begin
				if (!is_match && count_q < CNT_W'(MAX_TRACKS)) begin
					tbox_q[count_q[IDX_W-1:0]]    <= dbox_q;
					tcls_q[count_q[IDX_W-1:0]]    <= dcls_q;
					tconf_q[count_q[IDX_W-1:0]]   <= dconf_q;
					thits_q[count_q[IDX_W-1:0]]   <= 5'd1;
					tstreak_q[count_q[IDX_W-1:0]] <= 8'd1;
					tmiss_q[count_q[IDX_W-1:0]]   <= 3'd0;
				end
			end
			S_UPD: begin
				if (upd_k_q == 3'd4) begin
					tconf_q[best_q] <= cnew;
					if (thits_q[best_q] < HITS_CAP)
						thits_q[best_q] <= thits_q[best_q] + 5'd1;
					if (tstreak_q[best_q] < STREAK_MAX)
						tstreak_q[best_q] <= tstreak_q[best_q] + 8'd1;
					tmiss_q[best_q] <= 3'd0;
				end else begin
					tbox_q[best_q][upd_k_q[1:0]] <= quot;
				end
			end
			S_AGE: begin
				if (!at_end && keep) begin
					tbox_q[wp_q[IDX_W-1:0]]    <= tbox_q[cur];
					tcls_q[wp_q[IDX_W-1:0]]    <= tcls_q[cur];
					tconf_q[wp_q[IDX_W-1:0]]   <= tconf_q[cur];
					thits_q[wp_q[IDX_W-1:0]]   <= thits_q[cur];
					tstreak_q[wp_q[IDX_W-1:0]] <= tstreak_q[cur];
					tmiss_q[wp_q[IDX_W-1:0]]   <= miss_new;
				end
			end
			default: ;
		endcase
	end

	// sequencer, marks, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= 16'd16384;
			stable_q    <= 8'd2;
			matched_q   <= '0;
			fresh_q     <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			wp_q        <= '0;
			best_q      <= '0;
			best_vld_q  <= 1'b0;
			best_iou_q  <= '0;
			area_d_q    <= '0;
			iw_q        <= '0;
			ih_q        <= '0;
			inter_q     <= '0;
			uni_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			div_cnt_q   <= '0;
			upd_k_q     <= '0;
			n_q         <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_THRESHOLD: thr_q    <= cfg_data;
					CFG_STABLE:    stable_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (det_valid) begin
						idx_q <= '0;
						wp_q  <= '0;
						state_q <= (det.cmd == CMD_CLOSE) ? S_AGE : S_DAREA;
					end
				end
				S_DAREA: begin
					area_d_q   <= mul_p[31:0];
					best_vld_q <= 1'b0;
					best_iou_q <= '0;
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					if (at_end) begin
						state_q <= S_DECIDE;
					end else if (matched_q[cur] || tcls_q[cur] != dcls_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						iw_q    <= iw;
						ih_q    <= ih;
						state_q <= S_INTER;
					end
				end
				S_INTER: begin
					inter_q <= mul_p[33:0];
					state_q <= S_TAREA;
				end
				S_TAREA: begin
					uni_q   <= uni_d;
					state_q <= S_DIV0;
				end
				S_DIV0: begin
					if (uni_q == '0) begin
						// empty union: IoU is zero, never a candidate
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						rem_q     <= (inter_q >= uni_q) ? inter_q - uni_q : inter_q;
						quo_q     <= {16'b0, inter_q >= uni_q};
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem2 >= {1'b0, uni_q}) begin
						rem_q <= 34'(rem2 - {1'b0, uni_q});
						quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						rem_q <= rem2[33:0];
						quo_q <= {quo_q[15:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == 4'd15)
						state_q <= S_CMP;
				end
				S_CMP: begin
					if (quo_q > best_iou_q) begin
						best_iou_q <= quo_q;
						best_q     <= cur;
						best_vld_q <= 1'b1;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_DECIDE: begin
					if (is_match) begin
						upd_k_q <= '0;
						state_q <= S_UPD;
					end else if (count_q < CNT_W'(MAX_TRACKS)) begin
						matched_q[count_q[IDX_W-1:0]] <= 1'b0;
						fresh_q[count_q[IDX_W-1:0]]   <= 1'b1;
						count_q <= count_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						ovf_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_UPD: begin
					upd_k_q <= upd_k_q + 3'd1;
					if (upd_k_q == 3'd4) begin
						matched_q[best_q] <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_AGE: begin
					if (at_end) begin
						count_q   <= wp_q;
						matched_q <= '0;
						fresh_q   <= '0;
						idx_q     <= '0;
						n_q       <= '0;
						state_q   <= S_EMIT;
					end else begin
						if (keep)
							wp_q <= wp_q + 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					// at the end with nothing sent: no visible track this frame
					if (at_end || vis[cur]) begin
						res_q       <= res_d;
						res_valid_q <= 1'b1;
						if (!at_end)
							n_q <= n_q + 1'b1;
						state_q     <= S_WAIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (res_ready) begin
						res_valid_q <= 1'b0;
						if (res_q.last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_EMIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign det_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* rtl/core/iou_bt_checker.sv */
`include "iou_box_tracker_assert.svh"

module iou_bt_checker
	import iou_bt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic det_valid,
	input logic det_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// hold a stalled result
	`IOU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

	// stay busy in the cycle after a transfer in
	`IOU_ASSERT_NEXT(a_busy_after_det, det_valid && det_ready, !det_ready)

	// take no new item while a result waits
	`IOU_ASSERT_NOW(a_no_overlap, res_valid, !det_ready)

	// an empty frame report closes the frame
	`IOU_ASSERT_NOW(a_empty_is_last, res_valid && !res.valid_res, res.last)

endmodule

bind iou_box_tracker iou_bt_checker u_iou_bt_checker (.*);
